FILE: hdl/q4q8_pkg.sv
package q4q8_pkg;

    localparam int unsigned BLOCK_ELEMENTS = 32;
    localparam int unsigned HALF_ELEMS     = BLOCK_ELEMENTS / 2;

    localparam logic [31:0] FP_QNAN     = 32'hFFC0_0000;
    localparam logic [17:0] HALF_BIAS   = 18'h1_C000;
    localparam logic [9:0]  FP_BIAS     = 10'd127;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input request
        logic dot_lo;   // low nibbles times acts 0..15
        logic dot_hi;   // high nibbles times acts 16..31
        logic cvt;      // integer sum to fp32
        logic mul;      // mantissa product
        logic sel_act;  // multiply by activation scale, else weight scale
        logic rnd;      // round the product
        logic add;      // align and add to the accumulator
        logic commit;   // normalize, round, update accumulator
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hold;     // last block but the output register is still full and stalled
    } t_sts;

endpackage

FILE: hdl/q4_q8_block_dot_accumulate.sv
// q4_q8_block_dot_accumulate
// one request is a 32-element block pair: 16 packed 4-bit weight bytes with an
// fp16 scale, and 32 signed 8-bit activations with an fp16 scale
// input channel: i_in_valid / o_in_stall, accepted when valid and not stalled
// output channel: o_out_valid / i_out_stall, one row sum per request with last set
// the integer dot product is taken one half block at a time, low then high,
// converted to fp32, scaled by the weight then activation scale and added into
// the fp32 row accumulator, each step rounded to nearest even
// an item passes through accept, dot low, dot high, convert, then multiply and
// round for each scale, align-add and normalize; no new request is taken until
// normalize is done, as the fp multiplier is shared and the accumulator is added back
// the row sum shows on o_row_sum the cycle after normalize; the accumulator is
// then cleared for the next row
// if the receiver stalls, the result holds in the output register; further
// requests still run, and only a later last block waits at normalize
// reset (synchronous, active low) clears the accumulator to +0 and drops
// any pending result
module q4_q8_block_dot_accumulate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_weight_bytes_low,
    input  logic [63:0] i_weight_bytes_high,
    input  logic [63:0] i_acts_0_7,
    input  logic [63:0] i_acts_8_15,
    input  logic [63:0] i_acts_16_23,
    input  logic [63:0] i_acts_24_31,
    input  logic [15:0] i_weight_scale,
    input  logic [15:0] i_act_scale,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_row_sum
);
    import q4q8_pkg::*;

    t_cmd w_cmd;   // sequencer commands
    t_sts w_sts;   // datapath status

    q4q8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    q4q8_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_weight_bytes_low  (i_weight_bytes_low),
        .i_weight_bytes_high (i_weight_bytes_high),
        .i_acts_0_7          (i_acts_0_7),
        .i_acts_8_15         (i_acts_8_15),
        .i_acts_16_23        (i_acts_16_23),
        .i_acts_24_31        (i_acts_24_31),
        .i_weight_scale      (i_weight_scale),
        .i_act_scale         (i_act_scale),
        .i_last_block        (i_last_block),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_row_sum           (o_row_sum)
    );

endmodule

FILE: hdl/q4q8_ctrl.sv
module q4q8_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  q4q8_pkg::t_sts  i_sts,
    output q4q8_pkg::t_cmd  o_cmd
);
    import q4q8_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DOTL = 4'd1;
    localparam logic [3:0] S_DOTH = 4'd2;
    localparam logic [3:0] S_CVT  = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_RND1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_RND2 = 4'd7;
    localparam logic [3:0] S_ADD  = 4'd8;
    localparam logic [3:0] S_NORM = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DOTL;
                end
            end
            S_DOTL: begin
                o_cmd.dot_lo = 1'b1;
                n_state      = S_DOTH;
            end
            S_DOTH: begin
                o_cmd.dot_hi = 1'b1;
                n_state      = S_CVT;
            end
            S_CVT: begin
                o_cmd.cvt = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND1;
            end
            S_RND1: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul     = 1'b1;
                o_cmd.sel_act = 1'b1;
                n_state       = S_RND2;
            end
            S_RND2: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_NORM;
            end
            S_NORM: begin
                if (!i_sts.hold) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DOTL))
        else $error("accepted request did not start the dot phase");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.hold)
        else $error("commit while output register blocked");

    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM && !i_sts.hold) |=> (r_state == S_IDLE))
        else $error("normalize step did not finish");

endmodule

FILE: hdl/q4q8_dpath.sv
module q4q8_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  q4q8_pkg::t_cmd  i_cmd,
    output q4q8_pkg::t_sts  o_sts,
    input  logic [63:0]     i_weight_bytes_low,
    input  logic [63:0]     i_weight_bytes_high,
    input  logic [63:0]     i_acts_0_7,
    input  logic [63:0]     i_acts_8_15,
    input  logic [63:0]     i_acts_16_23,
    input  logic [63:0]     i_acts_24_31,
    input  logic [15:0]     i_weight_scale,
    input  logic [15:0]     i_act_scale,
    input  logic            i_last_block,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_row_sum
);
    import q4q8_pkg::*;

    // fp16 widening as the block format defines it
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [17:0] v_m;
        logic [31:0] v_r;
        begin
            v_m = {3'b000, h[14:0]} + HALF_BIAS;
            v_r = {h[15], 31'd0};
            if (h[14:0] != 15'd0) begin
                v_r = {h[15], v_m[17:0], 13'd0};
            end
            return v_r;
        end
    endfunction

    logic [127:0]        r_w;
    logic [255:0]        r_a;
    logic [15:0]         r_ws, r_as;
    logic                r_last;
    logic signed [16:0]  r_total;
    logic [31:0]         r_x;
    logic [47:0]         r_prod;
    logic signed [9:0]   r_pexp;
    logic                r_psign, r_pzero;
    logic [27:0]         r_sum;
    logic signed [9:0]   r_sexp;
    logic                r_ssign, r_szero, r_sspec;
    logic [31:0]         r_sval;
    logic [31:0]         r_acc;
    logic [31:0]         r_out;
    logic                r_out_valid;

    // dot product of one half block
    logic signed [15:0] v_half;
    always_comb begin
        logic [7:0]         v_wb;
        logic [3:0]         v_nib;
        logic signed [3:0]  v_q;
        logic signed [7:0]  v_act;
        logic signed [11:0] v_p;
        v_half = '0;
        for (int k = 0; k < HALF_ELEMS; k++) begin
            v_wb  = r_w[8*k +: 8];
            v_nib = i_cmd.dot_hi ? v_wb[7:4] : v_wb[3:0];
            v_q   = signed'({~v_nib[3], v_nib[2:0]});
            v_act = signed'(i_cmd.dot_hi ? r_a[128 + 8*k +: 8] : r_a[8*k +: 8]);
            v_p   = 12'(v_q) * 12'(v_act);
            v_half = v_half + 16'(v_p);
        end
    end

    // integer to fp32, exact
    logic [31:0] v_cvt;
    always_comb begin
        logic [15:0] v_mag;
        logic [4:0]  v_lz;
        logic [15:0] v_sh;
        v_mag = r_total[16] ? 16'(-r_total) : r_total[15:0];
        v_lz  = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v_mag[i]) v_lz = 5'(15 - i);
        end
        v_sh  = v_mag << v_lz;
        v_cvt = {r_total[16], 8'(8'd142 - {3'd0, v_lz}), v_sh[14:0], 8'd0};
        if (v_mag == 16'd0) v_cvt = 32'd0;
    end

    // product round
    logic [31:0] v_mr;
    always_comb begin
        logic [22:0]       v_m;
        logic              v_g, v_st, v_inc;
        logic signed [9:0] v_e;
        logic [31:0]       v_r;
        if (r_prod[47]) begin
            v_m = r_prod[46:24]; v_g = r_prod[23]; v_st = |r_prod[22:0];
            v_e = r_pexp + 10'sd1;
        end else begin
            v_m = r_prod[45:23]; v_g = r_prod[22]; v_st = |r_prod[21:0];
            v_e = r_pexp;
        end
        v_inc = v_g & (v_st | v_m[0]);
        v_r   = {1'b0, v_e[7:0], v_m} + {31'd0, v_inc};
        if (r_pzero || v_e <= 10'sd0) begin
            v_mr = {r_psign, 31'd0};
        end else if (v_e >= 10'sd255 || v_r[30:23] == 8'hFF) begin
            v_mr = {r_psign, 8'hFF, 23'd0};
        end else begin
            v_mr = {r_psign, v_r[30:0]};
        end
    end

    // add result normalize and round
    logic [31:0] v_res;
    always_comb begin
        logic [26:0]       v_n;
        logic signed [9:0] v_e;
        logic [4:0]        v_lz;
        logic [22:0]       v_m;
        logic              v_inc;
        logic [31:0]       v_r;
        v_lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r_sum[i]) v_lz = 5'(26 - i);
        end
        if (r_sum[27]) begin
            v_n = {r_sum[27:2], r_sum[1] | r_sum[0]};
            v_e = r_sexp + 10'sd1;
        end else begin
            v_n = r_sum[26:0] << v_lz;
            v_e = r_sexp - signed'({5'd0, v_lz});
        end
        v_m   = v_n[25:3];
        v_inc = v_n[2] & (v_n[1] | v_n[0] | v_m[0]);
        v_r   = {1'b0, v_e[7:0], v_m} + {31'd0, v_inc};
        if (r_sspec) begin
            v_res = r_sval;
        end else if (r_szero || v_e <= 10'sd0) begin
            v_res = {r_ssign & ~r_szero, 31'd0};
        end else if (v_e >= 10'sd255 || v_r[30:23] == 8'hFF) begin
            v_res = {r_ssign, 8'hFF, 23'd0};
        end else begin
            v_res = {r_ssign, v_r[30:0]};
        end
    end

    // align and add, accumulator first
    logic [27:0] v_sum;
    logic [8:0]  v_sexp;
    logic        v_ssign, v_spec;
    logic [31:0] v_sval;
    always_comb begin
        logic [31:0] v_big, v_sml;
        logic        v_nana, v_nanb, v_infa, v_infb, v_za, v_zb;
        logic [7:0]  v_d;
        logic [26:0] v_mb, v_ms, v_sh, v_mask;
        logic        v_st;
        v_nana = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] != 23'd0);
        v_nanb = (r_x[30:23] == 8'hFF) && (r_x[22:0] != 23'd0);
        v_infa = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] == 23'd0);
        v_infb = (r_x[30:23] == 8'hFF) && (r_x[22:0] == 23'd0);
        v_za   = (r_acc[30:0] == 31'd0);
        v_zb   = (r_x[30:0] == 31'd0);
        v_spec = 1'b1;
        v_sval = r_acc;
        priority if (v_nana || v_nanb || (v_infa && v_infb && r_acc[31] != r_x[31])) begin
            v_sval = FP_QNAN;
        end else if (v_infa) begin
            v_sval = r_acc;
        end else if (v_infb) begin
            v_sval = r_x;
        end else if (v_za && v_zb) begin
            v_sval = {r_acc[31] & r_x[31], 31'd0};
        end else if (v_za) begin
            v_sval = r_x;
        end else if (v_zb) begin
            v_sval = r_acc;
        end else begin
            v_spec = 1'b0;
        end
        if (r_x[30:0] > r_acc[30:0]) begin
            v_big = r_x;   v_sml = r_acc;
        end else begin
            v_big = r_acc; v_sml = r_x;
        end
        v_d    = v_big[30:23] - v_sml[30:23];
        v_mb   = {1'b1, v_big[22:0], 3'd0};
        v_ms   = {1'b1, v_sml[22:0], 3'd0};
        v_mask = '0;
        v_st   = 1'b0;
        if (v_d >= 8'd27) begin
            v_sh = 27'd1;
        end else begin
            v_mask = (27'd1 << v_d[4:0]) - 27'd1;
            v_st   = |(v_ms & v_mask);
            v_sh   = (v_ms >> v_d[4:0]) | {26'd0, v_st};
        end
        if (v_big[31] == v_sml[31]) begin
            v_sum = {1'b0, v_mb} + {1'b0, v_sh};
        end else begin
            v_sum = {1'b0, v_mb} - {1'b0, v_sh};
        end
        v_sexp  = {1'b0, v_big[30:23]};
        v_ssign = v_big[31];
    end

    logic [31:0] v_y;
    assign v_y = i_cmd.sel_act ? widen_half(r_as) : widen_half(r_ws);

    logic v_drain;
    assign v_drain = r_out_valid && !i_out_stall;
    assign o_sts.hold = r_last && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w    <= {i_weight_bytes_high, i_weight_bytes_low};
            r_a    <= {i_acts_24_31, i_acts_16_23, i_acts_8_15, i_acts_0_7};
            r_ws   <= i_weight_scale;
            r_as   <= i_act_scale;
            r_last <= i_last_block;
        end
        if (i_cmd.dot_lo) r_total <= 17'(v_half);
        if (i_cmd.dot_hi) r_total <= r_total + 17'(v_half);
        if (i_cmd.cvt)    r_x <= v_cvt;
        if (i_cmd.mul) begin
            r_prod  <= {24'd0, 1'b1, r_x[22:0]} * {24'd0, 1'b1, v_y[22:0]};
            r_pexp  <= signed'({2'd0, r_x[30:23]} + {2'd0, v_y[30:23]} - FP_BIAS);
            r_psign <= r_x[31] ^ v_y[31];
            r_pzero <= (r_x[30:23] == 8'd0) || (v_y[30:23] == 8'd0);
        end
        if (i_cmd.rnd) r_x <= v_mr;
        if (i_cmd.add) begin
            r_sum   <= v_sum;
            r_sexp  <= signed'({1'b0, v_sexp});
            r_ssign <= v_ssign;
            r_szero <= (v_sum == 28'd0);
            r_sspec <= v_spec;
            r_sval  <= v_sval;
        end
        if (i_cmd.commit && r_last) r_out <= v_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_acc <= r_last ? 32'd0 : v_res;
            end
            if (i_cmd.commit && r_last) begin
                r_out_valid <= 1'b1;
            end else if (v_drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_sum   = r_out;

endmodule

FILE: test/q4_q8_block_dot_accumulate_test.sv
`timescale 1ns / 1ps

module q4_q8_block_dot_accumulate_test;

    // fp16 scale codes used by the directed part
    localparam logic [15:0] HALF_POS_ZERO = 16'h0000;
    localparam logic [15:0] HALF_NEG_ZERO = 16'h8000;
    localparam logic [15:0] HALF_ONE      = 16'h3C00;
    localparam logic [15:0] HALF_NEG_ONE  = 16'hBC00;
    localparam logic [15:0] HALF_MAX_CODE = 16'h7FFF;
    localparam logic [15:0] HALF_NEG_MAX  = 16'hFFFF;
    localparam logic [15:0] HALF_MIN_CODE = 16'h0001;
    localparam logic [15:0] HALF_INF_CODE = 16'h7C00;
    localparam int          CLK_HALF      = 6;
    localparam int          DRAIN_CYCLES  = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_weight_bytes_low;
    logic [63:0] i_weight_bytes_high;
    logic [63:0] i_acts_0_7;
    logic [63:0] i_acts_8_15;
    logic [63:0] i_acts_16_23;
    logic [63:0] i_acts_24_31;
    logic [15:0] i_weight_scale;
    logic [15:0] i_act_scale;
    logic        i_last_block;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_row_sum;

    // predictor state: fp32 row sum as a bit pattern
    logic [31:0] row_sum_model;
    // row sums waiting to come out, oldest first
    logic [31:0] pending_sums[$];
    int          mismatches;
    int          out_stall_left;
    bit          out_taken;
    bit          no_idle;

    q4_q8_block_dot_accumulate i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_weight_bytes_low  (i_weight_bytes_low),
        .i_weight_bytes_high (i_weight_bytes_high),
        .i_acts_0_7          (i_acts_0_7),
        .i_acts_8_15         (i_acts_8_15),
        .i_acts_16_23        (i_acts_16_23),
        .i_acts_24_31        (i_acts_24_31),
        .i_weight_scale      (i_weight_scale),
        .i_act_scale         (i_act_scale),
        .i_last_block        (i_last_block),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_row_sum           (o_row_sum)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // soft fp32: value = mag * 2^ex, rounded to nearest even
    // inf and nan never arise here: widened scales are finite and one
    // block times both scales stays below 2^49
    // ------------------------------------------------------------------
    function automatic logic [31:0] fp32_round(input logic sgn, input logic [127:0] mag,
                                               input int ex);
        int           top;
        int           sh;
        int           eo;
        logic [127:0] q;
        logic [127:0] rest;
        logic [127:0] half;
        if (mag == 0) return {sgn, 31'b0};
        top = 0;
        for (int i = 0; i < 128; i++) if (mag[i]) top = i;
        sh = top - 23;
        eo = ex + sh;
        // below the normal range the lsb weight is pinned at 2^-149
        if (eo < -149) begin
            sh = sh + (-149 - eo);
            eo = -149;
        end
        if (sh <= 0) begin
            q = mag << (-sh);
        end else if (sh > 127) begin
            q = '0;
        end else begin
            q    = mag >> sh;
            rest = mag - (q << sh);
            half = 128'd1 << (sh - 1);
            if (rest > half || (rest == half && q[0])) q = q + 1;
        end
        if (q[24]) begin
            q  = q >> 1;
            eo = eo + 1;
        end
        if (!q[23]) return {sgn, 8'h00, q[22:0]};
        if (eo + 150 >= 255) return {sgn, 8'hFF, 23'b0};
        return {sgn, 8'(eo + 150), q[22:0]};
    endfunction

    function automatic void fp32_split(input logic [31:0] f, output logic sgn,
                                       output logic [127:0] mag, output int ex);
        sgn = f[31];
        if (f[30:23] == 8'h00) begin
            mag = 128'(f[22:0]);
            ex  = -149;
        end else begin
            mag = 128'({1'b1, f[22:0]});
            ex  = int'(f[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic         sa, sb;
        logic [127:0] ma, mb;
        int           ea, eb;
        fp32_split(a, sa, ma, ea);
        fp32_split(b, sb, mb, eb);
        return fp32_round(sa ^ sb, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
        logic         sa, sb;
        logic [127:0] ma, mb;
        int           ea, eb;
        int           d;
        fp32_split(a, sa, ma, ea);
        fp32_split(b, sb, mb, eb);
        if (ma == 0 && mb == 0) return {sa & sb, 31'b0};
        if (ma == 0) return b;
        if (mb == 0) return a;
        if (ea < eb) begin
            fp32_split(b, sa, ma, ea);
            fp32_split(a, sb, mb, eb);
        end
        d = ea - eb;
        // a far smaller operand only matters as a sticky bit below the round bit
        if (d > 60) begin
            ma = ma << 60;
            ea = ea - 60;
            mb = 128'd1;
        end else begin
            ma = ma << d;
            ea = eb;
        end
        if (sa == sb) return fp32_round(sa, ma + mb, ea);
        if (ma == mb) return 32'h0000_0000;
        if (ma > mb) return fp32_round(sa, ma - mb, ea);
        return fp32_round(sb, mb - ma, ea);
    endfunction

    // fp16 widening by rebias only, no subnormal or inf handling
    function automatic logic [31:0] widen_scale(input logic [15:0] h);
        logic [31:0] w;
        if (h[14:0] == 0) return {h[15], 31'b0};
        w = (32'(h[14:0]) + 32'h0001_C000) << 13;
        return {h[15], 31'b0} | w;
    endfunction

    // exact integer dot product of one block pair
    function automatic int block_int_dot(input logic [63:0] wl, input logic [63:0] wh,
                                         input logic [63:0] a0, input logic [63:0] a1,
                                         input logic [63:0] a2, input logic [63:0] a3);
        int         acc;
        logic [7:0] wb;
        logic [7:0] al;
        logic [7:0] ah;
        acc = 0;
        for (int j = 0; j < 16; j++) begin
            wb = (j < 8) ? wl[8*j +: 8] : wh[8*(j-8) +: 8];
            al = (j < 8) ? a0[8*j +: 8] : a1[8*(j-8) +: 8];
            ah = (j < 8) ? a2[8*j +: 8] : a3[8*(j-8) +: 8];
            acc += (int'(wb[3:0]) - 8) * int'($signed(al))
                 + (int'(wb[7:4]) - 8) * int'($signed(ah));
        end
        return acc;
    endfunction

    // fold one accepted block into the row sum, queue the sum on last
    task automatic accumulate_block();
        int          dot;
        logic [31:0] prod;
        dot  = block_int_dot(i_weight_bytes_low, i_weight_bytes_high, i_acts_0_7,
                             i_acts_8_15, i_acts_16_23, i_acts_24_31);
        prod = fp32_round(dot < 0, 128'(dot < 0 ? -dot : dot), 0);
        prod = fp32_mul(prod, widen_scale(i_weight_scale));
        prod = fp32_mul(prod, widen_scale(i_act_scale));
        row_sum_model = fp32_add(row_sum_model, prod);
        if (i_last_block) begin
            pending_sums.push_back(row_sum_model);
            row_sum_model = 32'h0000_0000;
        end
    endtask

    // send one request; called at a falling edge, returns at a falling edge
    task automatic send_block(input logic [63:0] wl, input logic [63:0] wh,
                              input logic [63:0] a0, input logic [63:0] a1,
                              input logic [63:0] a2, input logic [63:0] a3,
                              input logic [15:0] ws, input logic [15:0] as,
                              input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_weight_bytes_low  = wl;
        i_weight_bytes_high = wh;
        i_acts_0_7          = a0;
        i_acts_8_15         = a1;
        i_acts_16_23        = a2;
        i_acts_24_31        = a3;
        i_weight_scale      = ws;
        i_act_scale         = as;
        i_last_block        = last;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        accumulate_block();
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // scale mix: any code, moderate magnitudes, tiny codes, corner codes
    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom());
            2, 3: return {1'($urandom()), 15'($urandom_range(16'h3000, 16'h4800))};
            4:    return {1'($urandom()), 15'($urandom_range(0, 16'h03FF))};
            default: begin
                case ($urandom_range(0, 3))
                    0: return HALF_POS_ZERO;
                    1: return HALF_NEG_ZERO;
                    2: return HALF_MAX_CODE;
                    default: return HALF_NEG_MAX;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall per result, compare against oldest sum
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            out_stall_left = no_idle ? 0 : $urandom_range(0, 19);
        end
        if (out_stall_left > 0) begin
            i_out_stall = 1'b1;
            out_stall_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_taken = 1'b1;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row sum %h", o_row_sum);
            end else begin
                if (o_row_sum !== pending_sums[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row sum mismatch: expected %h actual %h",
                                 pending_sums[0], o_row_sum);
                end
                void'(pending_sums.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of weights, activations and scales; zero and corner scales
    task automatic test_directed();
        // all nibbles 0 (-8) times -128 gives the largest sum, +32768
        send_block('0, '0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                   HALF_ONE, HALF_ONE, 1'b1);
        // nibbles 15 (+7) times -128: a large negative sum, -28672
        send_block('1, '1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                   HALF_ONE, HALF_ONE, 1'b1);
        send_block('1, '1, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}},
                   HALF_NEG_ONE, HALF_ONE, 1'b1);
        // nibble 8 is a zero weight
        send_block({8{8'h88}}, {8{8'h88}}, '1, '1, '1, '1, HALF_ONE, HALF_ONE, 1'b1);
        // zero scales of both signs
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_POS_ZERO, HALF_ONE, 1'b1);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_ONE, HALF_NEG_ZERO, 1'b1);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_NEG_ZERO, HALF_NEG_ZERO, 1'b1);
        // inf and max codes widen to large finite values
        send_block('0, '0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                   HALF_MAX_CODE, HALF_NEG_MAX, 1'b1);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_INF_CODE, HALF_MAX_CODE, 1'b1);
        // smallest codes push the product toward underflow
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_MIN_CODE, HALF_MIN_CODE, 1'b1);
        send_block({8{8'h89}}, {8{8'h88}}, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01}, '0, '0, '0, HALF_MIN_CODE, 16'h8001, 1'b1);
        // a row of several blocks, then a row that cancels to zero
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   16'h3555, 16'h2E66, 1'b0);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   16'h4100, 16'hB800, 1'b0);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   16'h0200, 16'h3C01, 1'b1);
        send_block('0, '0, {8{8'h01}}, '0, '0, '0, HALF_ONE, HALF_ONE, 1'b0);
        send_block('0, '0, {8{8'h01}}, '0, '0, '0, HALF_NEG_ONE, HALF_ONE, 1'b1);
        // huge then tiny in one row: tiny is below rounding
        send_block('0, '0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                   HALF_MAX_CODE, HALF_MAX_CODE, 1'b0);
        send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                   HALF_MIN_CODE, 16'h8002, 1'b1);
    endtask

    // random rows of 1..8 blocks
    task automatic test_random_rows(input int blocks);
        int sent;
        int row_len;
        sent = 0;
        while (sent < blocks) begin
            row_len = $urandom_range(1, 8);
            for (int k = 1; k <= row_len; k++)
                send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                           pick_scale(), pick_scale(), k == row_len);
            sent += row_len;
        end
    endtask

    // back-to-back requests with no idle gaps and no output stall from the bench
    task automatic test_full_rate();
        no_idle = 1'b1;
        test_random_rows(150);
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_weight_bytes_low  = '0;
        i_weight_bytes_high = '0;
        i_acts_0_7          = '0;
        i_acts_8_15         = '0;
        i_acts_16_23        = '0;
        i_acts_24_31        = '0;
        i_weight_scale      = '0;
        i_act_scale         = '0;
        i_last_block        = 1'b0;
        i_out_stall         = 1'b0;
        out_stall_left      = 0;
        out_taken           = 1'b0;
        no_idle             = 1'b0;
        mismatches          = 0;
        row_sum_model       = 32'h0000_0000;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_rows(600);
        test_full_rate();
        test_random_rows(550);

        i_in_valid = 1'b0;
        wait (pending_sums.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("** q4_q8_block_dot_accumulate: PASSED **");
        else
            $display("** q4_q8_block_dot_accumulate: FAILED **");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #20ms;
        $display("** q4_q8_block_dot_accumulate: FAILED **");
        $finish;
    end

endmodule
